FILE: sv/rss_pkg.sv
// Shared widths, constants and the statistics snapshot type for the running statistics block.
`default_nettype none
package rss_pkg;

	localparam int SAMPLE_BITS = 16;
	localparam int COUNT_BITS  = 20;
	localparam int SUM_W       = 36;
	localparam int SQ_W        = 52;
	localparam int NUM_W       = 72;
	localparam int DEN_W       = 40;
	localparam int MEAN_W      = 24;
	localparam int VAR_W       = 31;
	localparam int SD_W        = 16;
	localparam int IN_DATA_W   = 16;
	localparam int OUT_DATA_W  = 144;

	localparam logic [COUNT_BITS-1:0] CNT_MAX = {COUNT_BITS{1'b1}};
	localparam logic signed [SAMPLE_BITS-1:0] SMP_POS = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
	localparam logic signed [SAMPLE_BITS-1:0] SMP_NEG = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

	// Iteration counts of the back end.
	localparam int MUL_STEPS  = 6;
	localparam int DIV_STEPS  = 31;
	localparam int MEAN_STEPS = 24;
	localparam int SQRT_STEPS = 16;

	// Accumulated state after one sample, handed from front to back.
	typedef struct packed {
		logic [COUNT_BITS-1:0]         count;
		logic signed [SUM_W-1:0]       sum;
		logic [SQ_W-1:0]               sum_sq;
		logic signed [SAMPLE_BITS-1:0] min_v;
		logic signed [SAMPLE_BITS-1:0] max_v;
		logic signed [SAMPLE_BITS-1:0] last_v;
		logic                          full;
	} snap_t;

endpackage
`default_nettype wire

FILE: sv/rss_front.sv
// Front end: accepts samples and updates count, sums, minimum, maximum and last sample.
`default_nettype none
module rss_front (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          in_valid,
	input  wire logic [rss_pkg::IN_DATA_W-1:0] in_data,
	input  wire logic                          q_full,
	output logic                               in_ready,
	output logic                               push,
	output rss_pkg::snap_t                     push_data
);
	import rss_pkg::*;

	logic [COUNT_BITS-1:0]         count_q;
	logic signed [SUM_W-1:0]       sum_q;
	logic [SQ_W-1:0]               sum_sq_q;
	logic signed [SAMPLE_BITS-1:0] min_q;
	logic signed [SAMPLE_BITS-1:0] max_q;
	logic signed [SAMPLE_BITS-1:0] last_q;
	logic signed [SAMPLE_BITS-1:0] smp;
	logic [2*SAMPLE_BITS-1:0]      smp_sq;
	snap_t                         nxt;

	assign smp      = $signed(in_data[SAMPLE_BITS-1:0]);
	assign smp_sq   = $unsigned((2*SAMPLE_BITS)'(smp) * (2*SAMPLE_BITS)'(smp));
	assign in_ready = !q_full;
	assign push     = in_valid && in_ready;

	// Next state: sums freeze once the count saturates.
	always_comb begin
		nxt.count  = count_q;
		nxt.sum    = sum_q;
		nxt.sum_sq = sum_sq_q;
		if (count_q != CNT_MAX) begin
			nxt.count  = count_q + 1'b1;
			nxt.sum    = sum_q + SUM_W'(smp);
			nxt.sum_sq = sum_sq_q + SQ_W'(smp_sq);
		end
		nxt.min_v  = (smp < min_q) ? smp : min_q;
		nxt.max_v  = (smp > max_q) ? smp : max_q;
		nxt.last_v = smp;
		nxt.full   = (nxt.count == CNT_MAX);
	end

	assign push_data = nxt;

	// Statistics registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q  <= '0;
			sum_q    <= '0;
			sum_sq_q <= '0;
			min_q    <= SMP_POS;
			max_q    <= SMP_NEG;
			last_q   <= '0;
		end else if (push) begin
			count_q  <= nxt.count;
			sum_q    <= nxt.sum;
			sum_sq_q <= nxt.sum_sq;
			min_q    <= nxt.min_v;
			max_q    <= nxt.max_v;
			last_q   <= nxt.last_v;
		end
	end

	// The last sample register mirrors the pushed snapshot.
	assert property (@(posedge clk) disable iff (!arst_n)
		push |=> last_q == $past(smp))
		else $error("last sample not captured");

endmodule
`default_nettype wire

FILE: sv/rss_fifo.sv
// Two-entry queue of statistics snapshots between front and back end.
`default_nettype none
module rss_fifo (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           push,
	input  rss_pkg::snap_t      push_data,
	input  wire logic           pop,
	output logic                full,
	output logic                empty,
	output rss_pkg::snap_t      pop_data
);
	import rss_pkg::*;

	snap_t       mem_q [2];
	logic        wr_ptr_q;
	logic        rd_ptr_q;
	logic [1:0]  cnt_q;

	assign full     = cnt_q[1];
	assign empty    = (cnt_q == 2'd0);
	assign pop_data = mem_q[rd_ptr_q];

	// Entry storage.
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n) cnt_q != 2'd3)
		else $error("queue count out of range");
	assert property (@(posedge clk) disable iff (!arst_n) !(pop && empty))
		else $error("pop from empty queue");

endmodule
`default_nettype wire

FILE: sv/rss_back.sv
// Back end: mean, variance and square root by shared multiplier and iterative units.
`default_nettype none
module rss_back (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           q_empty,
	input  rss_pkg::snap_t                      q_data,
	output logic                                pop,
	output logic                                out_valid,
	input  wire logic                           out_ready,
	output logic [rss_pkg::OUT_DATA_W-1:0]      out_data,
	output logic                                out_full
);
	import rss_pkg::*;

	typedef enum logic [5:0] {
		ST_IDLE = 6'b000001,
		ST_MUL  = 6'b000010,
		ST_PREP = 6'b000100,
		ST_DIV  = 6'b001000,
		ST_SQRT = 6'b010000,
		ST_OUT  = 6'b100000
	} state_t;

	state_t                        state_q;
	logic [4:0]                    step_q;
	snap_t                         snap_q;
	logic [SUM_W-1:0]              mag_q;
	logic                          neg_q;
	logic [25:0]                   opa;
	logic [25:0]                   opb;
	logic [51:0]                   prod;
	logic [NUM_W-1:0]              acc_t_q;
	logic [NUM_W-1:0]              acc_s_q;
	logic [DEN_W-1:0]              den_q;
	logic [NUM_W-1:0]              num;
	logic [DEN_W-1:0]              rem_q;
	logic [VAR_W-1:0]              div_q;
	logic [DEN_W:0]                r2;
	logic                          ge;
	logic [COUNT_BITS-1:0]         mrem_q;
	logic [MEAN_W-1:0]             mdiv_q;
	logic [COUNT_BITS:0]           mr2;
	logic                          mge;
	logic [31:0]                   x_q;
	logic [17:0]                   srem_q;
	logic [SD_W-1:0]               root_q;
	logic [19:0]                   sr;
	logic [19:0]                   trial;
	logic                          sge;
	logic signed [MEAN_W-1:0]      mean;
	logic [OUT_DATA_W-1:0]         out_q;
	logic                          full_q;

	assign pop       = (state_q == ST_IDLE) && !q_empty;
	assign out_valid = (state_q == ST_OUT);
	assign out_data  = out_q;
	assign out_full  = full_q;

	// Shared multiplier operand selection.
	always_comb begin
		case (step_q)
			5'd0: begin
				opa = snap_q.sum_sq[25:0];
				opb = 26'(snap_q.count);
			end
			5'd1: begin
				opa = snap_q.sum_sq[51:26];
				opb = 26'(snap_q.count);
			end
			5'd2: begin
				opa = 26'(mag_q[17:0]);
				opb = 26'(mag_q[17:0]);
			end
			5'd3: begin
				opa = 26'(mag_q[17:0]);
				opb = 26'(mag_q[35:18]);
			end
			5'd4: begin
				opa = 26'(mag_q[35:18]);
				opb = 26'(mag_q[35:18]);
			end
			default: begin
				opa = 26'(snap_q.count);
				opb = 26'(snap_q.count);
			end
		endcase
	end
	assign prod = opa * opb;

	// Variance numerator, floored at zero.
	assign num = (acc_t_q >= acc_s_q) ? (acc_t_q - acc_s_q) : '0;

	// One restoring step each for the variance and mean dividers.
	assign r2  = {rem_q, div_q[VAR_W-1]};
	assign ge  = (r2 >= {1'b0, den_q});
	assign mr2 = {mrem_q, mdiv_q[MEAN_W-1]};
	assign mge = (mr2 >= {1'b0, snap_q.count});

	// One digit step of the square root.
	assign sr    = {srem_q, x_q[31:30]};
	assign trial = {2'b00, root_q, 2'b01};
	assign sge   = (sr >= trial);

	// Signed mean with range clamp.
	always_comb begin
		if (neg_q) begin
			mean = (mdiv_q > 24'd8388608) ? 24'sh800000 : -$signed(mdiv_q);
		end else begin
			mean = (mdiv_q > 24'd8388607) ? 24'sh7FFFFF : $signed(mdiv_q);
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				snap_q <= q_data;
				neg_q  <= q_data.sum[SUM_W-1];
				mag_q  <= q_data.sum[SUM_W-1] ? SUM_W'(-q_data.sum) : SUM_W'(q_data.sum);
			end
			ST_MUL: begin
				case (step_q)
					5'd0:    acc_t_q <= NUM_W'(prod);
					5'd1:    acc_t_q <= acc_t_q + (NUM_W'(prod) << 26);
					5'd2:    acc_s_q <= NUM_W'(prod);
					5'd3:    acc_s_q <= acc_s_q + (NUM_W'(prod) << 19);
					5'd4:    acc_s_q <= acc_s_q + (NUM_W'(prod) << 36);
					default: den_q   <= prod[DEN_W-1:0];
				endcase
			end
			ST_PREP: begin
				rem_q  <= num[DEN_W+VAR_W-1:VAR_W];
				div_q  <= num[VAR_W-1:0];
				mrem_q <= mag_q[SUM_W-1:SUM_W-COUNT_BITS];
				mdiv_q <= {mag_q[SUM_W-COUNT_BITS-1:0], 8'd0};
			end
			ST_DIV: begin
				rem_q <= ge ? DEN_W'(r2 - {1'b0, den_q}) : r2[DEN_W-1:0];
				div_q <= {div_q[VAR_W-2:0], ge};
				if (step_q < 5'(MEAN_STEPS)) begin
					mrem_q <= mge ? COUNT_BITS'(mr2 - {1'b0, snap_q.count})
						: mr2[COUNT_BITS-1:0];
					mdiv_q <= {mdiv_q[MEAN_W-2:0], mge};
				end
				if (step_q == 5'(DIV_STEPS - 1)) begin
					x_q    <= {1'b0, div_q[VAR_W-2:0], ge};
					srem_q <= '0;
					root_q <= '0;
				end
			end
			ST_SQRT: begin
				srem_q <= sge ? 18'(sr - trial) : sr[17:0];
				root_q <= {root_q[SD_W-2:0], sge};
				x_q    <= {x_q[29:0], 2'b00};
				if (step_q == 5'(SQRT_STEPS - 1)) begin
					out_q <= {5'd0, root_q[SD_W-2:0], sge, div_q, mean,
						snap_q.last_v, snap_q.max_v, snap_q.min_v, snap_q.count};
					full_q <= snap_q.full;
				end
			end
			default: begin
			end
		endcase
	end

	// Sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			step_q  <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					step_q <= '0;
					if (!q_empty) begin
						state_q <= ST_MUL;
					end
				end
				ST_MUL: begin
					if (step_q == 5'(MUL_STEPS - 1)) begin
						step_q  <= '0;
						state_q <= ST_PREP;
					end else begin
						step_q <= step_q + 5'd1;
					end
				end
				ST_PREP: begin
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					if (step_q == 5'(DIV_STEPS - 1)) begin
						step_q  <= '0;
						state_q <= ST_SQRT;
					end else begin
						step_q <= step_q + 5'd1;
					end
				end
				ST_SQRT: begin
					if (step_q == 5'(SQRT_STEPS - 1)) begin
						step_q  <= '0;
						state_q <= ST_OUT;
					end else begin
						step_q <= step_q + 5'd1;
					end
				end
				ST_OUT: begin
					if (out_ready) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV) |-> step_q < 5'(DIV_STEPS))
		else $error("divider step out of range");
	assert property (@(posedge clk) disable iff (!arst_n)
		pop |=> state_q == ST_MUL && step_q == 5'd0)
		else $error("snapshot taken without starting the multiply pass");

endmodule
`default_nettype wire

FILE: sv/running_sample_statistics.sv
// Top level of the running sample statistics block.
// Each input word carries one signed sample; each output word carries count, minimum,
// maximum, latest sample, Q8 mean, population variance and its integer square root.
// The front end updates the running sums in the cycle a word is accepted and queues a
// snapshot in a two-entry queue; the back end works one snapshot at a time: it loads
// it, runs six multiply steps on a shared 26x26 multiplier, a setup state, 31 restoring
// divider steps (the 24 mean steps run alongside) and 16 square root steps, then the
// result is presented and held until it is taken. Input is taken while the queue has
// room, so up to two more samples are accepted while a result is being computed or
// waits to be taken.
`default_nettype none
module running_sample_statistics (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            s_axis_tvalid,
	output logic                                 s_axis_tready,
	input  wire logic [rss_pkg::IN_DATA_W-1:0]   s_axis_tdata,  // sample[15:0]
	output logic                                 m_axis_tvalid,
	input  wire logic                            m_axis_tready,
	// sample_count[19:0], minimum[35:20], maximum[51:36], latest[67:52],
	// mean_q8[91:68], variance[122:92], std_dev[138:123], zero fill above
	output logic [rss_pkg::OUT_DATA_W-1:0]       m_axis_tdata,
	output logic                                 m_axis_tuser   // full_res
);
	import rss_pkg::*;

	logic  push;
	logic  pop;
	logic  q_full;
	logic  q_empty;
	snap_t push_data;
	snap_t pop_data;

	// Sample intake and running sums.
	rss_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_data   (s_axis_tdata),
		.q_full    (q_full),
		.in_ready  (s_axis_tready),
		.push      (push),
		.push_data (push_data)
	);

	// Snapshot queue.
	rss_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.pop       (pop),
		.full      (q_full),
		.empty     (q_empty),
		.pop_data  (pop_data)
	);

	// Derived statistics.
	rss_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_empty   (q_empty),
		.q_data    (pop_data),
		.pop       (pop),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_data  (m_axis_tdata),
		.out_full  (m_axis_tuser)
	);

endmodule
`default_nettype wire
